// File: rtl/delayed_leader_follow_ndi_control_macros.svh
// ----------------------------------------------------------------------------
// delayed_leader_follow_ndi_control_macros.svh
// Assertion shorthands used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef DELAYED_LEADER_FOLLOW_NDI_CONTROL_MACROS_SVH
`define DELAYED_LEADER_FOLLOW_NDI_CONTROL_MACROS_SVH

// same-cycle implication
`define DLF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dlf_pkg.sv
// ----------------------------------------------------------------------------
// dlf_pkg
// Shared types, register codes and saturation helpers.
// ----------------------------------------------------------------------------
package dlf_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TAU_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CMD  = 3'd5;

    localparam logic [30:0]        RST_TAU_X   = 31'd196608;
    localparam logic [30:0]        RST_TAU_Y   = 31'd196608;
    localparam logic signed [31:0] RST_GAIN_P  = -32'sd98304;
    localparam logic signed [31:0] RST_GAIN_D  = -32'sd196608;
    localparam logic [30:0]        RST_DELAY   = 31'd262144;
    localparam logic [30:0]        RST_MAX_CMD = 31'd6554;

    // one ring entry
    typedef struct packed {
        logic [31:0]        time_v;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] fvel_x;
        logic signed [31:0] fvel_y;
        logic signed [31:0] lvel_x;
        logic signed [31:0] lvel_y;
        logic signed [31:0] yaw;
        logic signed [31:0] lacc_x;
        logic signed [31:0] lacc_y;
    } t_sample;

    localparam int SAMPLE_W = $bits(t_sample);

    // operands for the control law sequencer
    typedef struct packed {
        logic signed [31:0] u1;
        logic signed [31:0] v1;
        logic signed [31:0] r;
        logic signed [31:0] u2;
        logic signed [31:0] v2;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] xd;
        logic signed [31:0] yd;
        logic signed [31:0] du;
        logic signed [31:0] dv;
    } t_law_ops;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(64'(a) - 64'(b));
    endfunction

endpackage

// File: rtl/dlf_ram.sv
// ----------------------------------------------------------------------------
// dlf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/dlf_law.sv
// ----------------------------------------------------------------------------
// dlf_law
// NDI control law on one shared saturating Q16.16 multiplier, op by op.
// ----------------------------------------------------------------------------
module dlf_law (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  dlf_pkg::t_law_ops     i_ops,
    input  logic [30:0]           i_tau_x,
    input  logic [30:0]           i_tau_y,
    input  logic signed [31:0]    i_gain_p,
    input  logic signed [31:0]    i_gain_d,
    output logic                  o_done,
    output logic signed [31:0]    o_cx,
    output logic signed [31:0]    o_cy
);
    import dlf_pkg::*;

    localparam logic [4:0] ST_EX  = 5'd0;
    localparam logic [4:0] ST_EY  = 5'd1;
    localparam logic [4:0] ST_WX0 = 5'd2;
    localparam logic [4:0] ST_WX1 = 5'd3;
    localparam logic [4:0] ST_WY0 = 5'd4;
    localparam logic [4:0] ST_WY1 = 5'd5;
    localparam logic [4:0] ST_RR  = 5'd6;
    localparam logic [4:0] ST_RTX = 5'd7;
    localparam logic [4:0] ST_RTY = 5'd8;
    localparam logic [4:0] ST_CX0 = 5'd9;
    localparam logic [4:0] ST_CX1 = 5'd10;
    localparam logic [4:0] ST_CX2 = 5'd11;
    localparam logic [4:0] ST_CX3 = 5'd12;
    localparam logic [4:0] ST_CX4 = 5'd13;
    localparam logic [4:0] ST_CY0 = 5'd14;
    localparam logic [4:0] ST_CY1 = 5'd15;
    localparam logic [4:0] ST_CY2 = 5'd16;
    localparam logic [4:0] ST_CY3 = 5'd17;
    localparam logic [4:0] ST_CY4 = 5'd18;

    logic               r_busy, r_ph, r_done;
    logic [4:0]         r_step;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_ex, r_ey, r_wx, r_wy, r_rr, r_rtx, r_rty, r_cx, r_cy;
    logic signed [31:0] op_a, op_b, m;
    logic signed [31:0] tx, ty;

    assign tx = $signed({1'b0, i_tau_x});
    assign ty = $signed({1'b0, i_tau_y});
    assign m  = sat32(r_prod >>> 16);

    always_comb begin
        op_a = i_ops.r;
        op_b = i_ops.r;
        unique case (r_step)
            ST_EX:  begin op_a = i_ops.r;  op_b = i_ops.yd; end
            ST_EY:  begin op_a = i_ops.r;  op_b = i_ops.xd; end
            ST_WX0: begin op_a = i_gain_p; op_b = i_ops.xd; end
            ST_WX1: begin op_a = i_gain_d; op_b = r_ex;     end
            ST_WY0: begin op_a = i_gain_p; op_b = i_ops.yd; end
            ST_WY1: begin op_a = i_gain_d; op_b = r_ey;     end
            ST_RR:  begin op_a = i_ops.r;  op_b = i_ops.r;  end
            ST_RTX: begin op_a = i_ops.r;  op_b = tx;       end
            ST_RTY: begin op_a = i_ops.r;  op_b = ty;       end
            ST_CX0: begin op_a = r_rr;     op_b = i_ops.xd; end
            ST_CX1: begin op_a = r_rtx;    op_b = i_ops.v1; end
            ST_CX2: begin op_a = i_ops.ax; op_b = tx;       end
            ST_CX3: begin op_a = sat_add(r_rtx, r_rtx); op_b = i_ops.v2; end
            ST_CX4: begin op_a = tx;       op_b = r_wx;     end
            ST_CY0: begin op_a = r_rr;     op_b = i_ops.yd; end
            ST_CY1: begin op_a = r_rty;    op_b = i_ops.u1; end
            ST_CY2: begin op_a = i_ops.ay; op_b = ty;       end
            ST_CY3: begin op_a = sat_add(r_rty, r_rty); op_b = i_ops.u2; end
            ST_CY4: begin op_a = ty;       op_b = r_wy;     end
            default: begin op_a = i_ops.r; op_b = i_ops.r; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && r_ph && (r_step == ST_CY4);
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
                r_step <= ST_EX;
            end else if (r_busy) begin
                r_ph <= !r_ph;
                if (r_ph) begin
                    if (r_step == ST_CY4) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
            end
        end
    end

    // product on the first half, writeback on the second
    always_ff @(posedge i_clk) begin
        if (r_busy && !r_ph) begin
            r_prod <= op_a * op_b;
        end
        if (r_busy && r_ph) begin
            unique case (r_step)
                ST_EX:  r_ex  <= sat_add(i_ops.du, m);
                ST_EY:  r_ey  <= sat_sub(i_ops.dv, m);
                ST_WX0: r_wx  <= m;
                ST_WX1: r_wx  <= sat_add(r_wx, m);
                ST_WY0: r_wy  <= m;
                ST_WY1: r_wy  <= sat_add(r_wy, m);
                ST_RR:  r_rr  <= m;
                ST_RTX: r_rtx <= m;
                ST_RTY: r_rty <= m;
                ST_CX0: r_cx  <= sat_sub(i_ops.u1, m);
                ST_CX1: r_cx  <= sat_sub(r_cx, m);
                ST_CX2: r_cx  <= sat_add(r_cx, m);
                ST_CX3: r_cx  <= sat_add(r_cx, m);
                ST_CX4: r_cx  <= sat_sub(r_cx, m);
                ST_CY0: r_cy  <= sat_sub(i_ops.v1, m);
                ST_CY1: r_cy  <= sat_add(r_cy, m);
                ST_CY2: r_cy  <= sat_add(r_cy, m);
                ST_CY3: r_cy  <= sat_sub(r_cy, m);
                ST_CY4: r_cy  <= sat_sub(r_cy, m);
                default: r_cy <= r_cy;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cx   = r_cx;
    assign o_cy   = r_cy;
endmodule

// File: rtl/dlf_lim.sv
// ----------------------------------------------------------------------------
// dlf_lim
// Norm limiter: squared norm, bitwise square root, restoring divide per axis.
// ----------------------------------------------------------------------------
module dlf_lim (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic [30:0]        i_max_cmd,
    output logic               o_done,
    output logic signed [31:0] o_vx,
    output logic signed [31:0] o_vy
);
    import dlf_pkg::*;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_SQY  = 3'd1;
    localparam logic [2:0] L_SQM  = 3'd2;
    localparam logic [2:0] L_CMP  = 3'd3;
    localparam logic [2:0] L_ROOT = 3'd4;
    localparam logic [2:0] L_MUL  = 3'd5;
    localparam logic [2:0] L_DIVI = 3'd6;
    localparam logic [2:0] L_DIV  = 3'd7;

    logic [2:0]         r_st;
    logic               r_done, r_sel;
    logic [4:0]         r_it;
    logic signed [31:0] r_cx, r_cy, r_vx, r_vy;
    logic [63:0]        r_prod, r_sum, r_op;
    logic [32:0]        r_srem;
    logic [31:0]        r_root, r_drem;
    logic [30:0]        r_dvd, r_q;
    logic [31:0]        abs_x, abs_y, abs_sel;
    logic [34:0]        sq_rem, sq_trial;
    logic [32:0]        dv_rem;
    logic               sq_take, dv_take, neg_sel;
    logic signed [31:0] q_signed;

    assign abs_x    = r_cx[31] ? 32'(-r_cx) : 32'(r_cx);
    assign abs_y    = r_cy[31] ? 32'(-r_cy) : 32'(r_cy);
    assign abs_sel  = r_sel ? abs_y : abs_x;
    assign neg_sel  = r_sel ? r_cy[31] : r_cx[31];
    assign sq_rem   = {r_srem, r_op[63:62]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_take  = sq_rem >= sq_trial;
    assign dv_rem   = {r_drem, r_dvd[30]};
    assign dv_take  = dv_rem >= {1'b0, r_root};
    assign q_signed = neg_sel ? -$signed({1'b0, r_q[29:0], dv_take})
                              : $signed({1'b0, r_q[29:0], dv_take});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
            r_sel  <= 1'b0;
            r_it   <= '0;
        end else begin
            // done when the norm fits, or after the second divide
            r_done <= ((r_st == L_CMP) && !(r_sum > r_prod))
                   || ((r_st == L_DIV) && (r_it == '0) && r_sel);
            unique case (r_st)
                L_IDLE: if (i_start) r_st <= L_SQY;
                L_SQY:  r_st <= L_SQM;
                L_SQM:  r_st <= L_CMP;
                L_CMP: begin
                    if (r_sum > r_prod) begin
                        r_it <= 5'd31;
                        r_st <= L_ROOT;
                    end else begin
                        r_st <= L_IDLE;
                    end
                end
                L_ROOT: begin
                    r_it <= r_it - 5'd1;
                    if (r_it == '0) begin
                        r_sel <= 1'b0;
                        r_st  <= L_MUL;
                    end
                end
                L_MUL:  r_st <= L_DIVI;
                L_DIVI: begin
                    r_it <= 5'd30;
                    r_st <= L_DIV;
                end
                L_DIV: begin
                    r_it <= r_it - 5'd1;
                    if (r_it == '0) begin
                        if (!r_sel) begin
                            r_sel <= 1'b1;
                            r_st  <= L_MUL;
                        end else begin
                            r_st  <= L_IDLE;
                        end
                    end
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            L_IDLE: begin
                r_cx   <= i_cx;
                r_cy   <= i_cy;
                r_prod <= 64'(i_cx[31] ? 32'(-i_cx) : 32'(i_cx))
                        * 64'(i_cx[31] ? 32'(-i_cx) : 32'(i_cx));
            end
            L_SQY: begin
                r_sum  <= r_prod;
                r_prod <= 64'(abs_y) * 64'(abs_y);
            end
            L_SQM: begin
                r_sum  <= r_sum + r_prod;
                r_prod <= 64'(i_max_cmd) * 64'(i_max_cmd);
            end
            L_CMP: begin
                r_op   <= r_sum;
                r_srem <= '0;
                r_root <= '0;
                r_vx   <= r_cx;
                r_vy   <= r_cy;
            end
            L_ROOT: begin
                r_op <= {r_op[61:0], 2'b00};
                if (sq_take) begin
                    r_srem <= 33'(sq_rem - sq_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_srem <= sq_rem[32:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            L_MUL:  r_prod <= 64'(abs_sel) * 64'(i_max_cmd);
            L_DIVI: begin
                // quotient stays below 2^31, so the top half is already reduced
                r_drem <= {1'b0, r_prod[61:31]};
                r_dvd  <= r_prod[30:0];
                r_q    <= '0;
            end
            L_DIV: begin
                r_dvd  <= {r_dvd[29:0], 1'b0};
                r_q    <= {r_q[29:0], dv_take};
                r_drem <= dv_take ? 32'(dv_rem - {1'b0, r_root}) : dv_rem[31:0];
                if (r_it == '0) begin
                    if (r_sel) r_vy <= q_signed;
                    else       r_vx <= q_signed;
                end
            end
            default: r_prod <= r_prod;
        endcase
    end

    assign o_done = r_done;
    assign o_vx   = r_vx;
    assign o_vy   = r_vy;
endmodule

// File: rtl/delayed_leader_follow_ndi_control.sv
// ----------------------------------------------------------------------------
// delayed_leader_follow_ndi_control
// Delayed leader-follow velocity controller (NDI law), Q16.16, ring in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid / o_stall) takes one timestamped sample per beat.
//  Output channel (o_valid / i_stall) gives one command beat per input beat.
//  Config channel (i_cfg_valid / o_cfg_ready) writes tau_x, tau_y, gain_p,
//  gain_d, delay_time and the norm limit by index; ready is always high, and
//  writes should be made while the block is idle. Out-of-range indexes are
//  ignored.
// Steps from acceptance to o_valid: front scan (read, check, drop if stale),
//  integration over kept entries (read, multiply, accumulate), operand setup,
//  law sequencer (product, then writeback per multiply), norm compare, then
//  32 root steps and a divide per axis when the norm limit applies, output.
//  The single RAM read port and the shared multiply units serialize these steps.
//  o_stall is high from acceptance until the result is in the output register;
//  the next sample can be taken in the same cycle that o_valid rises at the earliest.
// Reset: ring pointers and count clear, config registers take their defaults; the
//  ring RAM itself is not cleared, only written entries are ever read.
// A stalled result holds in the output register; the next sample may be
//  accepted meanwhile, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
`include "delayed_leader_follow_ndi_control_macros.svh"

module delayed_leader_follow_ndi_control #(
    parameter int RING_DEPTH = dlf_pkg::RING_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [31:0]                    i_time_now,
    input  logic signed [31:0]             i_rel_x,
    input  logic signed [31:0]             i_rel_y,
    input  logic signed [31:0]             i_follower_vx,
    input  logic signed [31:0]             i_follower_vy,
    input  logic signed [31:0]             i_leader_vx,
    input  logic signed [31:0]             i_leader_vy,
    input  logic signed [31:0]             i_yaw_rate,
    input  logic signed [31:0]             i_leader_ax,
    input  logic signed [31:0]             i_leader_ay,
    // command channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [31:0]             o_cmd_vx,
    output logic signed [31:0]             o_cmd_vy,
    // config channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import dlf_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int ACC_W = 49 + IDX_W;   // 48-bit terms, RING_DEPTH of them

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_INT_RD   = 4'd3;
    localparam logic [3:0] S_INT_MUL  = 4'd4;
    localparam logic [3:0] S_INT_ACC  = 4'd5;
    localparam logic [3:0] S_FIN      = 4'd6;
    localparam logic [3:0] S_LAW      = 4'd7;
    localparam logic [3:0] S_LIM      = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(RING_DEPTH - 1)) ? '0 : x + IDX_W'(1);
    endfunction

    // ---------------- config registers ----------------
    logic [30:0]        r_tau_x, r_tau_y, r_delay, r_max_cmd;
    logic signed [31:0] r_gain_p, r_gain_d;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau_x   <= RST_TAU_X;
            r_tau_y   <= RST_TAU_Y;
            r_gain_p  <= RST_GAIN_P;
            r_gain_d  <= RST_GAIN_D;
            r_delay   <= RST_DELAY;
            r_max_cmd <= RST_MAX_CMD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TAU_X:   r_tau_x   <= i_cfg_data[30:0];
                CFG_TAU_Y:   r_tau_y   <= i_cfg_data[30:0];
                CFG_GAIN_P:  r_gain_p  <= $signed(i_cfg_data);
                CFG_GAIN_D:  r_gain_d  <= $signed(i_cfg_data);
                CFG_DELAY:   r_delay   <= i_cfg_data[30:0];
                CFG_MAX_CMD: r_max_cmd <= i_cfg_data[30:0];
                default:     r_delay   <= r_delay;
            endcase
        end
    end

    // ---------------- ring control ----------------
    logic [3:0]             r_state;
    logic [IDX_W-1:0]       r_oldest, r_wr, r_ptr;
    logic [CNT_W-1:0]       r_count, r_k;
    logic                   r_law_start, r_lim_start;
    logic                   r_out_valid;
    logic                   in_acc, out_acc, out_free;

    // sample payload kept for the whole step
    logic [31:0]            r_tnow;
    logic signed [31:0]     r_u1, r_v1, r_r;
    t_sample                r_front;
    logic [31:0]            r_prev_t;
    logic signed [31:0]     r_prev_fx, r_prev_fy;
    logic signed [63:0]     r_px, r_py;
    logic signed [ACC_W-1:0] r_ix, r_iy;
    t_law_ops               r_ops;
    logic signed [31:0]     r_res_x, r_res_y, r_out_vx, r_out_vy;

    // RAM
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    t_sample                wr_sample, rd_sample;
    logic [SAMPLE_W-1:0]    ram_rdata;

    // datapath helpers
    logic [31:0]            age, dt;
    logic                   stale;
    logic signed [64:0]     prod_x, prod_y;
    logic signed [31:0]     ix_sat, iy_sat, xd, yd;

    // units
    logic                   law_done, lim_done;
    logic signed [31:0]     law_cx, law_cy, lim_vx, lim_vy;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_cmd_vx = r_out_vx;
    assign o_cmd_vy = r_out_vy;

    assign wr_sample = '{time_v: i_time_now, pos_x: i_rel_x, pos_y: i_rel_y,
                         fvel_x: i_follower_vx, fvel_y: i_follower_vy,
                         lvel_x: i_leader_vx, lvel_y: i_leader_vy,
                         yaw: i_yaw_rate, lacc_x: i_leader_ax, lacc_y: i_leader_ay};
    assign ram_we    = in_acc;
    assign ram_raddr = (r_state == S_INT_RD) ? r_ptr : r_oldest;
    assign rd_sample = t_sample'(ram_rdata);

    dlf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (wr_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // front entry is stale when it lags the new sample by more than the delay
    assign age   = r_tnow - rd_sample.time_v;
    assign stale = age > {1'b0, r_delay};

    // interval from the previous entry to this one, times previous velocity
    assign dt     = rd_sample.time_v - r_prev_t;
    assign prod_x = $signed({1'b0, dt}) * r_prev_fx;
    assign prod_y = $signed({1'b0, dt}) * r_prev_fy;

    assign ix_sat = sat32(64'(r_ix));
    assign iy_sat = sat32(64'(r_iy));
    assign xd     = sat_sub(r_front.pos_x, ix_sat);
    assign yd     = sat_sub(r_front.pos_y, iy_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_wr        <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_ptr       <= '0;
            r_law_start <= 1'b0;
            r_lim_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_law_start <= (r_state == S_FIN);
            r_lim_start <= (r_state == S_LAW) && law_done;
            // a finished result loads the output register as soon as it frees
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // full ring: the oldest entry makes room first
                        if (r_count == CNT_W'(RING_DEPTH)) begin
                            r_oldest <= inc_idx(r_oldest);
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_wr    <= inc_idx(r_wr);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (stale) begin
                        r_oldest <= inc_idx(r_oldest);
                        r_count  <= r_count - CNT_W'(1);
                        r_state  <= S_SCAN_RD;
                    end else begin
                        r_ptr   <= inc_idx(r_oldest);
                        r_k     <= CNT_W'(1);
                        r_state <= (r_count == CNT_W'(1)) ? S_FIN : S_INT_RD;
                    end
                end
                S_INT_RD:  r_state <= S_INT_MUL;
                S_INT_MUL: r_state <= S_INT_ACC;
                S_INT_ACC: begin
                    r_ptr <= inc_idx(r_ptr);
                    r_k   <= r_k + CNT_W'(1);
                    r_state <= (r_k + CNT_W'(1) == r_count) ? S_FIN : S_INT_RD;
                end
                S_FIN: r_state <= S_LAW;
                S_LAW: begin
                    if (law_done) r_state <= S_LIM;
                end
                S_LIM: begin
                    if (lim_done) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tnow <= i_time_now;
            r_u1   <= i_follower_vx;
            r_v1   <= i_follower_vy;
            r_r    <= i_yaw_rate;
        end
        if (r_state == S_SCAN_CHK) begin
            r_front   <= rd_sample;
            r_prev_t  <= rd_sample.time_v;
            r_prev_fx <= rd_sample.fvel_x;
            r_prev_fy <= rd_sample.fvel_y;
            r_ix      <= '0;
            r_iy      <= '0;
        end
        if (r_state == S_INT_MUL) begin
            r_px      <= prod_x[63:0];
            r_py      <= prod_y[63:0];
            r_prev_t  <= rd_sample.time_v;
            r_prev_fx <= rd_sample.fvel_x;
            r_prev_fy <= rd_sample.fvel_y;
        end
        if (r_state == S_INT_ACC) begin
            // floor of each term, summed exactly
            r_ix <= r_ix + ACC_W'(r_px >>> 16);
            r_iy <= r_iy + ACC_W'(r_py >>> 16);
        end
        if (r_state == S_FIN) begin
            r_ops <= '{u1: r_u1, v1: r_v1, r: r_r,
                       u2: r_front.lvel_x, v2: r_front.lvel_y,
                       ax: r_front.lacc_x, ay: r_front.lacc_y,
                       xd: xd, yd: yd,
                       du: sat_sub(r_front.lvel_x, r_u1),
                       dv: sat_sub(r_front.lvel_y, r_v1)};
        end
        if (r_state == S_LIM && lim_done) begin
            r_res_x <= lim_vx;
            r_res_y <= lim_vy;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_vx <= r_res_x;
            r_out_vy <= r_res_y;
        end
    end

    dlf_law u_law (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_law_start),
        .i_ops    (r_ops),
        .i_tau_x  (r_tau_x),
        .i_tau_y  (r_tau_y),
        .i_gain_p (r_gain_p),
        .i_gain_d (r_gain_d),
        .o_done   (law_done),
        .o_cx     (law_cx),
        .o_cy     (law_cy)
    );

    dlf_lim u_lim (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_lim_start),
        .i_cx      (law_cx),
        .i_cy      (law_cy),
        .i_max_cmd (r_max_cmd),
        .o_done    (lim_done),
        .o_vx      (lim_vx),
        .o_vy      (lim_vy)
    );

    // ---------------- assertions ----------------
    `DLF_ASSERT_NOW(a_count_live, i_clk, i_rst_n, r_state != S_IDLE, r_count != '0, "empty ring")
    `DLF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state == S_SCAN_RD, "no scan")
    `DLF_ASSERT_NOW(a_law_phase, i_clk, i_rst_n, law_done, r_state == S_LAW, "law done early")
    `DLF_ASSERT_NOW(a_lim_phase, i_clk, i_rst_n, lim_done, r_state == S_LIM, "limiter done early")
endmodule
